### rtl/vdm_pkg.sv
// Shared types and constants for the valley detector with cluster merging.
package vdm_pkg;

   localparam int PosBits   = 12;
   localparam int DepthBits = 16;
   localparam int CsrBits   = 2;

   // configuration register indexes
   localparam logic [CsrBits-1:0] CsrSearchStart   = 2'd0;
   localparam logic [CsrBits-1:0] CsrSearchEnd     = 2'd1;
   localparam logic [CsrBits-1:0] CsrDepthThresh   = 2'd2;
   localparam logic [CsrBits-1:0] CsrMergeGap      = 2'd3;

   // configuration reset values
   localparam logic [PosBits-1:0]   SearchStartRst = 12'd620;
   localparam logic [PosBits-1:0]   SearchEndRst   = 12'd1300;
   localparam logic [DepthBits-1:0] DepthThreshRst = 16'd30;
   localparam logic [PosBits-1:0]   MergeGapRst    = 12'd20;

   typedef struct packed {
      logic [PosBits-1:0]   valley_position;
      logic [DepthBits-1:0] valley_depth;
      logic                 found;
      logic                 frame_done;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   typedef struct packed {
      logic [PosBits-1:0]   search_start;
      logic [PosBits-1:0]   search_end;
      logic [DepthBits-1:0] depth_threshold;
      logic [PosBits-1:0]   merge_gap;
   } cfg_type;

endpackage

### rtl/valley_detect_merge_top.sv
// Top level of the valley detector: input register, config registers, core and result queue.
//
// Usage: push one filtered sample per item on the req_ channel, with req_frame_end
// high on the last sample of a frame. Positions count from 0 at each frame start.
// Results leave on the rsp_ channel: one item per cluster of merged valleys with
// its deepest member (earliest on ties), or one marker item with rsp_found low
// when a frame had no valley. rsp_frame_done marks the last item of each frame.
// A valley is judged when the sample after it arrives.
// Path: a result is offered on rsp_ once the item that causes it has passed the input
// register and then been written to the result queue; the item waits in the input
// register while the queue lacks room for two items.
// Throughput: one sample per cycle; the input register is released only when the
// four-entry result queue has room for two items, so an item that causes two
// results stalls the input only if the receiver cannot keep up.
// Stall: rsp_stall holds the queue head stable; once the queue holds more than two
// items, a waiting input item is held and req_stall rises.
// Reset (synchronous, active high) empties the queue, clears frame state and loads
// the default window 620..1300, depth threshold 30 and merge gap 20.
// csr_ writes take effect at once and are meant for idle periods only.
module valley_detect_merge_top import vdm_pkg::*; #(
   parameter int MAX_FRAME_LEN = 4096,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PosBits-1:0]     rsp_valley_position,
   output logic [DepthBits-1:0]   rsp_valley_depth,
   output logic                   rsp_found,
   output logic                   rsp_frame_done,
   input  logic                   csr_write_enable,
   input  logic [CsrBits-1:0]     csr_index,
   input  logic [DepthBits-1:0]   csr_write_data
);

   cfg_type cfg_ff;
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   frame_end_ff;
   logic                   room2, fire, accept, pop;
   push_type               push;
   rsp_item_type           head;

   assign fire      = in_valid_ff && room2;
   assign req_stall = in_valid_ff && !room2;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_start    <= SearchStartRst;
         cfg_ff.search_end      <= SearchEndRst;
         cfg_ff.depth_threshold <= DepthThreshRst;
         cfg_ff.merge_gap       <= MergeGapRst;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrSearchStart: cfg_ff.search_start    <= csr_write_data[PosBits-1:0];
            CsrSearchEnd:   cfg_ff.search_end      <= csr_write_data[PosBits-1:0];
            CsrDepthThresh: cfg_ff.depth_threshold <= csr_write_data;
            CsrMergeGap:    cfg_ff.merge_gap       <= csr_write_data[PosBits-1:0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff    <= req_sample;
         frame_end_ff <= req_frame_end;
      end
   end

   vdm_core #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .fire     (fire),
      .sample   (sample_ff),
      .frame_end(frame_end_ff),
      .push     (push)
   );

   vdm_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .room2    (room2),
      .out_valid(rsp_valid),
      .out_item (head)
   );

   assign rsp_valley_position = head.valley_position;
   assign rsp_valley_depth    = head.valley_depth;
   assign rsp_found           = head.found;
   assign rsp_frame_done      = head.frame_done;

endmodule

### rtl/vdm_core.sv
// Valley test, cluster tracking and result formation for one sample per cycle, on cycles with fire high.
module vdm_core import vdm_pkg::*; #(
   parameter int MAX_FRAME_LEN = 4096,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   fire,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   frame_end,
   output push_type               push
);

   localparam int PW = $clog2(MAX_FRAME_LEN + 1);
   localparam int DW = SAMPLE_BITS + 1;
   localparam int CW = PW + PosBits;
   localparam logic [PW-1:0] MaxPos = PW'(MAX_FRAME_LEN);
   localparam logic [PW-1:0] FirstJudged = PW'(2);
   localparam logic [PW-1:0] OnePos = PW'(1);

   logic signed [SAMPLE_BITS-1:0] older_ff, older_in;
   logic signed [SAMPLE_BITS-1:0] middle_ff, middle_in;
   logic [PW-1:0] pos_cnt_ff, pos_cnt_in;
   logic [PW-1:0] best_pos_ff, best_pos_in;
   logic [DW-1:0] best_depth_ff, best_depth_in;
   logic [PW-1:0] last_raw_ff, last_raw_in;
   logic          cluster_open_ff, cluster_open_in;
   logic          any_emitted_ff, any_emitted_in;

   logic signed [SAMPLE_BITS-1:0] cur;
   logic [PW-1:0] idx;
   logic [PW-1:0] spacing;
   logic [DW-1:0] depth;
   logic          judged, in_window, depth_ok, raw, joined, close_old, final_emit;
   logic [DW+DepthBits-1:0] depth_wide, thr_wide, best_wide, best_next_wide;
   rsp_item_type  closed_item, final_item;
   logic [CW-1:0] pos_wide, best_pos_wide, best_pos_next_wide;

   assign cur     = sample;
   assign idx     = pos_cnt_ff - OnePos;
   assign spacing = idx - last_raw_ff;
   assign depth   = '0 - {middle_ff[SAMPLE_BITS-1], middle_ff};

   assign judged    = (pos_cnt_ff >= FirstJudged) && (pos_cnt_ff < MaxPos);
   assign pos_wide  = {{PosBits{1'b0}}, idx};
   assign in_window = (pos_wide >= {{PW{1'b0}}, cfg.search_start})
                   && (pos_wide <= {{PW{1'b0}}, cfg.search_end});
   assign depth_wide = {{DepthBits{1'b0}}, depth};
   assign thr_wide   = {{DW{1'b0}}, cfg.depth_threshold};
   assign depth_ok   = !depth[DW-1] && (depth_wide >= thr_wide);
   assign raw = judged && in_window && (middle_ff < older_ff) && (middle_ff <= cur)
             && depth_ok;
   assign joined = cluster_open_ff
                && ({{PosBits{1'b0}}, spacing} <= {{PW{1'b0}}, cfg.merge_gap});
   assign close_old = raw && !joined && cluster_open_ff;

   always_comb begin
      best_pos_in   = best_pos_ff;
      best_depth_in = best_depth_ff;
      last_raw_in   = last_raw_ff;
      if (raw) begin
         last_raw_in = idx;
         if (!joined || (depth > best_depth_ff)) begin
            best_pos_in   = idx;
            best_depth_in = depth;
         end
      end
   end

   assign cluster_open_in = cluster_open_ff | raw;
   assign any_emitted_in  = any_emitted_ff | close_old;
   assign older_in        = middle_ff;
   assign middle_in       = cur;
   assign pos_cnt_in      = (pos_cnt_ff < MaxPos) ? pos_cnt_ff + OnePos : pos_cnt_ff;

   assign best_wide          = {{DepthBits{1'b0}}, best_depth_ff};
   assign best_next_wide     = {{DepthBits{1'b0}}, best_depth_in};
   assign best_pos_wide      = {{PosBits{1'b0}}, best_pos_ff};
   assign best_pos_next_wide = {{PosBits{1'b0}}, best_pos_in};

   always_comb begin
      closed_item.valley_position = best_pos_wide[PosBits-1:0];
      closed_item.valley_depth    = best_wide[DepthBits-1:0];
      closed_item.found           = 1'b1;
      closed_item.frame_done      = 1'b0;
      if (cluster_open_in) begin
         final_item.valley_position = best_pos_next_wide[PosBits-1:0];
         final_item.valley_depth    = best_next_wide[DepthBits-1:0];
         final_item.found           = 1'b1;
      end else begin
         // no valley anywhere in the frame: marker item
         final_item.valley_position = '0;
         final_item.valley_depth    = '0;
         final_item.found           = 1'b0;
      end
      final_item.frame_done = 1'b1;
   end

   assign final_emit = frame_end && (cluster_open_in || !any_emitted_in);

   always_comb begin
      push.first  = closed_item;
      push.second = final_item;
      push.count  = 2'd0;
      if (fire) begin
         if (close_old) begin
            push.count = final_emit ? 2'd2 : 2'd1;
            if (frame_end && !final_emit) begin
               push.first.frame_done = 1'b1;
            end
         end else if (final_emit) begin
            push.count = 2'd1;
            push.first = final_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff        <= '0;
         middle_ff       <= '0;
         pos_cnt_ff      <= '0;
         best_pos_ff     <= '0;
         best_depth_ff   <= '0;
         last_raw_ff     <= '0;
         cluster_open_ff <= 1'b0;
         any_emitted_ff  <= 1'b0;
      end else if (fire) begin
         if (frame_end) begin
            // drop all frame state
            older_ff        <= '0;
            middle_ff       <= '0;
            pos_cnt_ff      <= '0;
            best_pos_ff     <= '0;
            best_depth_ff   <= '0;
            last_raw_ff     <= '0;
            cluster_open_ff <= 1'b0;
            any_emitted_ff  <= 1'b0;
         end else begin
            older_ff        <= older_in;
            middle_ff       <= middle_in;
            pos_cnt_ff      <= pos_cnt_in;
            best_pos_ff     <= best_pos_in;
            best_depth_ff   <= best_depth_in;
            last_raw_ff     <= last_raw_in;
            cluster_open_ff <= cluster_open_in;
            any_emitted_ff  <= any_emitted_in;
         end
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.first.frame_done && push.second.frame_done))
      else $error("two-item push out of order");

   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && !push.first.found) |->
         (push.count == 2'd1 && push.first.frame_done && !cluster_open_ff))
      else $error("no-valley marker with other items");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && frame_end) |=> (pos_cnt_ff == '0 && !cluster_open_ff))
      else $error("frame state not cleared");

endmodule

### rtl/vdm_rsp_fifo.sv
// Four-entry result queue taking up to two items per cycle.
module vdm_rsp_fifo import vdm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output logic         room2,
   output logic         out_valid,
   output rsp_item_type out_item
);

   localparam logic [2:0] Depth = 3'd4;

   rsp_item_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_next;

   assign wr_next   = wr_ptr_ff + 2'd1;
   assign room2     = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_item  = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> ({1'b0, count_ff} + {2'b0, push.count} <= {1'b0, Depth}))
      else $error("result queue overflow");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (count_ff == 3'd0))
      else $error("result queue not empty after reset");

   a_pop_advance: assert property (@(posedge clock) disable iff (reset)
      (pop && out_valid) |=> (rd_ptr_ff == $past(rd_ptr_ff) + 2'd1))
      else $error("read pointer did not advance");

endmodule
